@@ design/pcx_pkg.sv @@
// ----------------------------------------------------------------------------
// pcx_pkg: shared types and constants of the PCX run-length decoder
// Field widths, result and phase codes, controller states and the command
// and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pcx_pkg;

  // Field and counter widths
  localparam int unsigned ImgW   = 25;        // image byte count and bytes written
  localparam int unsigned RemW   = ImgW + 1;  // remaining bytes with borrow bit
  localparam int unsigned CntW   = 6;         // run length
  localparam int unsigned ColorW = 9;         // distinct colors, 0..256
  localparam int unsigned NColor = 256;

  // Count byte marker and repeat field
  localparam logic [7:0]      RunMark = 8'hC0;
  localparam logic [CntW-1:0] RunMask = 6'h3F;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_OVERRUN = 2'd2,
    KIND_SHORT   = 2'd3
  } kind_e;

  // Image phase
  typedef enum logic [1:0] {
    PHASE_ACTIVE   = 2'd0,
    PHASE_COMPLETE = 2'd1,
    PHASE_ERROR    = 2'd2
  } phase_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECODE,
    ST_RUN,
    ST_TAIL
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic   capture;     // latch the accepted request
    logic   calc_rem;    // compute remaining image bytes
    logic   clear;       // start a new image
    logic   start;       // decode the byte and load the pixel count
    logic   step_pixel;  // one pixel sent: advance counters
    logic   drop_run;    // drop a held repeat count
    logic   phase_wr;
    phase_e phase_val;
    logic   emit;        // load the output register
    kind_e  emit_kind;
    logic   emit_last;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op;            // 1 for a data byte, 0 for a new image
    logic eob;
    logic active;        // phase is active
    logic full;          // no room left on arrival
    logic fits;          // the pending run fits the image
    logic cnt_zero;
    logic cnt_one;
    logic rem_zero;
    logic rem_one;
    logic out_free;      // output register can take a result
  } stat_t;

endpackage

@@ design/pcx_rle_decoder.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_decoder: PCX run-length decoder with used-color count
// Expands a compressed PCX byte stream into bitmap bytes.
// ----------------------------------------------------------------------------
// Requests (op_i, data_byte_i, end_of_buffer_i) are taken when in_valid_i is
// high and in_stall_o is low; op 0 starts a new image, op 1 carries a byte.
// Results (kind_o, pixel_byte_o, last_o, colors_used_o) are taken when
// out_valid_o is high and out_stall_i is low; last_o marks the final result
// of a request. image_bytes is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle; the block does not check.
// One request is worked on at a time by the controller sequence. A request
// holds in_stall_o from accept until the controller is idle again. It goes
// through the evaluate and decode states; a new-image or ignored request, or
// a byte that finds the image already full, returns to idle from decode, and
// any other byte goes on through the pixel loop and the tail state. A full
// image result is loaded in decode, each pixel in the pixel loop and a
// closing result in the tail state. Each pixel of a run costs one cycle of
// the pixel loop unless the receiver stalls; the run state is re-evaluated
// once per request. A receiver stall holds the output register and pauses
// the pixel loop; no result is lost. Reset clears the run state, counters,
// phase and color map at once and sets image_bytes to 1; the block is ready.
// ----------------------------------------------------------------------------
module pcx_rle_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [pcx_pkg::ImgW-1:0]    cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_buffer_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  pixel_byte_o,
  output logic                        last_o,
  output logic [pcx_pkg::ColorW-1:0]  colors_used_o
);

  pcx_pkg::ctrl_t cmd;
  pcx_pkg::stat_t sts;

  // Controller
  pcx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  pcx_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .pixel_byte_o    (pixel_byte_o),
    .last_o          (last_o),
    .colors_used_o   (colors_used_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ design/pcx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcx_ctrl: decoder controller
// Sequences one request at a time: evaluate room left, decode the byte,
// send its pixels, then send the closing result, if any.
// ----------------------------------------------------------------------------
module pcx_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pcx_pkg::stat_t  sts_i,
  output pcx_pkg::ctrl_t  cmd_o
);

  pcx_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_stall_o       = 1'b1;
    cmd_o.capture    = 1'b0;
    cmd_o.calc_rem   = 1'b0;
    cmd_o.clear      = 1'b0;
    cmd_o.start      = 1'b0;
    cmd_o.step_pixel = 1'b0;
    cmd_o.drop_run   = 1'b0;
    cmd_o.phase_wr   = 1'b0;
    cmd_o.phase_val  = pcx_pkg::PHASE_ACTIVE;
    cmd_o.emit       = 1'b0;
    cmd_o.emit_kind  = pcx_pkg::KIND_PIXEL;
    cmd_o.emit_last  = 1'b0;

    unique case (state_q)
      pcx_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pcx_pkg::ST_EVAL;
        end
      end

      pcx_pkg::ST_EVAL: begin
        cmd_o.calc_rem = 1'b1;
        state_d        = pcx_pkg::ST_DECODE;
      end

      pcx_pkg::ST_DECODE: begin
        if (!sts_i.op) begin
          cmd_o.clear = 1'b1;
          state_d     = pcx_pkg::ST_IDLE;
        end else if (!sts_i.active) begin
          state_d = pcx_pkg::ST_IDLE;
        end else if (sts_i.full) begin
          // Image already full on arrival: report completion
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = pcx_pkg::KIND_DONE;
            cmd_o.emit_last = 1'b1;
            cmd_o.phase_wr  = 1'b1;
            cmd_o.phase_val = pcx_pkg::PHASE_COMPLETE;
            state_d         = pcx_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.start = 1'b1;
          state_d     = pcx_pkg::ST_RUN;
        end
      end

      pcx_pkg::ST_RUN: begin
        if (sts_i.cnt_zero) begin
          state_d = pcx_pkg::ST_TAIL;
        end else if (sts_i.out_free) begin
          // Last pixel is final only when nothing follows it
          cmd_o.emit       = 1'b1;
          cmd_o.emit_kind  = pcx_pkg::KIND_PIXEL;
          cmd_o.emit_last  = sts_i.cnt_one & sts_i.fits & !sts_i.rem_one & !sts_i.eob;
          cmd_o.step_pixel = 1'b1;
        end
      end

      pcx_pkg::ST_TAIL: begin
        if (!sts_i.fits) begin
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = pcx_pkg::KIND_OVERRUN;
            cmd_o.emit_last = 1'b1;
            cmd_o.phase_wr  = 1'b1;
            cmd_o.phase_val = pcx_pkg::PHASE_ERROR;
            state_d         = pcx_pkg::ST_IDLE;
          end
        end else if (sts_i.rem_zero) begin
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = pcx_pkg::KIND_DONE;
            cmd_o.emit_last = 1'b1;
            cmd_o.phase_wr  = 1'b1;
            cmd_o.phase_val = pcx_pkg::PHASE_COMPLETE;
            cmd_o.drop_run  = 1'b1;
            state_d         = pcx_pkg::ST_IDLE;
          end
        end else if (sts_i.eob) begin
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = pcx_pkg::KIND_SHORT;
            cmd_o.emit_last = 1'b1;
            cmd_o.phase_wr  = 1'b1;
            cmd_o.phase_val = pcx_pkg::PHASE_ERROR;
            cmd_o.drop_run  = 1'b1;
            state_d         = pcx_pkg::ST_IDLE;
          end
        end else begin
          state_d = pcx_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pcx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/pcx_dpath.sv @@
// ----------------------------------------------------------------------------
// pcx_dpath: decoder datapath
// Holds the image byte count, run state, byte counters, used-color map and
// the output register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module pcx_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [pcx_pkg::ImgW-1:0]     cfg_wdata_i,
  // request payload
  input  logic                         op_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_buffer_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   pixel_byte_o,
  output logic                         last_o,
  output logic [pcx_pkg::ColorW-1:0]   colors_used_o,
  // controller link
  input  pcx_pkg::ctrl_t               cmd_i,
  output pcx_pkg::stat_t               sts_o
);

  logic [pcx_pkg::ImgW-1:0]   image_q;
  logic [pcx_pkg::ImgW-1:0]   written_q;
  logic [pcx_pkg::RemW-1:0]   rem_q;
  logic                       pending_q;
  logic [pcx_pkg::CntW-1:0]   run_len_q;
  logic [pcx_pkg::CntW-1:0]   cnt_q;
  logic                       fits_q;
  pcx_pkg::phase_e            phase_q;
  logic [pcx_pkg::NColor-1:0] seen_q;
  logic [pcx_pkg::ColorW-1:0] count_q;

  logic                       op_q;
  logic [7:0]                 byte_q;
  logic                       eob_q;
  logic                       seen_rd_q;

  logic                       out_valid_q;
  pcx_pkg::kind_e             kind_q;
  logic [7:0]                 pixel_q;
  logic                       last_q;
  logic [pcx_pkg::ColorW-1:0] colors_q;

  logic                       is_count;
  logic                       fits_c;
  logic [pcx_pkg::CntW-1:0]   emit_cnt;
  logic                       mark_en;
  logic                       out_free;

  // Byte decode and run fit against the remaining room
  assign is_count = (byte_q & pcx_pkg::RunMark) == pcx_pkg::RunMark;
  assign fits_c   = {{(pcx_pkg::RemW-pcx_pkg::CntW){1'b0}}, run_len_q} <= rem_q;
  assign emit_cnt = fits_c ? run_len_q : rem_q[pcx_pkg::CntW-1:0];
  assign mark_en  = cmd_i.start & (pending_q ? fits_c : !is_count);
  assign out_free = !out_valid_q | !out_stall_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q <= pcx_pkg::ImgW'(1);
    end else if (cfg_we_i) begin
      image_q <= cfg_wdata_i;
    end
  end

  // Capture the request and look up its color flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      byte_q    <= data_byte_i;
      eob_q     <= end_of_buffer_i;
      seen_rd_q <= seen_q[data_byte_i];
    end
  end

  // Remaining room and pixel count
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_rem) begin
      rem_q <= {1'b0, image_q} - {1'b0, written_q};
    end else if (cmd_i.step_pixel) begin
      rem_q <= rem_q - pcx_pkg::RemW'(1);
    end
    if (cmd_i.start) begin
      if (pending_q) begin
        cnt_q  <= emit_cnt;
        fits_q <= fits_c;
      end else begin
        cnt_q  <= is_count ? '0 : pcx_pkg::CntW'(1);
        fits_q <= 1'b1;
      end
    end else if (cmd_i.step_pixel) begin
      cnt_q <= cnt_q - pcx_pkg::CntW'(1);
    end
  end

  // Image state: run, counters, phase and color map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      run_len_q <= '0;
      written_q <= '0;
      phase_q   <= pcx_pkg::PHASE_ACTIVE;
      seen_q    <= '0;
      count_q   <= '0;
    end else if (cmd_i.clear) begin
      pending_q <= 1'b0;
      run_len_q <= '0;
      written_q <= '0;
      phase_q   <= pcx_pkg::PHASE_ACTIVE;
      seen_q    <= '0;
      count_q   <= '0;
    end else begin
      if (cmd_i.start) begin
        if (pending_q) begin
          pending_q <= 1'b0;
          run_len_q <= '0;
        end else if (is_count) begin
          pending_q <= 1'b1;
          run_len_q <= byte_q[pcx_pkg::CntW-1:0] & pcx_pkg::RunMask;
        end
      end else if (cmd_i.drop_run) begin
        pending_q <= 1'b0;
        run_len_q <= '0;
      end
      if (mark_en && !seen_rd_q) begin
        seen_q[byte_q] <= 1'b1;
        count_q        <= count_q + pcx_pkg::ColorW'(1);
      end
      if (cmd_i.step_pixel) begin
        written_q <= written_q + pcx_pkg::ImgW'(1);
      end
      if (cmd_i.phase_wr) begin
        phase_q <= cmd_i.phase_val;
      end
    end
  end

  // Output register: hold while stalled, load on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q   <= cmd_i.emit_kind;
      pixel_q  <= (cmd_i.emit_kind == pcx_pkg::KIND_PIXEL) ? byte_q : 8'h00;
      last_q   <= cmd_i.emit_last;
      colors_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign pixel_byte_o  = pixel_q;
  assign last_o        = last_q;
  assign colors_used_o = colors_q;

  // Status to the controller
  assign sts_o.op       = op_q;
  assign sts_o.eob      = eob_q;
  assign sts_o.active   = phase_q == pcx_pkg::PHASE_ACTIVE;
  assign sts_o.full     = rem_q[pcx_pkg::RemW-1] | (rem_q == '0);
  assign sts_o.fits     = fits_q;
  assign sts_o.cnt_zero = cnt_q == '0;
  assign sts_o.cnt_one  = cnt_q == pcx_pkg::CntW'(1);
  assign sts_o.rem_zero = rem_q == '0;
  assign sts_o.rem_one  = rem_q == pcx_pkg::RemW'(1);
  assign sts_o.out_free = out_free;

  // A pixel is sent only with count left and room in the image
  a_pixel_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_pixel |-> (cnt_q != '0) && (rem_q != '0) && !rem_q[pcx_pkg::RemW-1])
    else $error("pixel sent without count or room");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over a stalled one");

  // Color count never exceeds the number of byte values
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pcx_pkg::ColorW'(pcx_pkg::NColor))
    else $error("color count out of range");

endmodule

@@ dv/pcx_rle_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_decoder_tb: self-checking testbench for the PCX run-length decoder
// Drives a directed set of images, then random well-formed and broken
// streams with random sender gaps and receiver stalls. A scoreboard class
// tracks the image state and predicts every result in order.
// ----------------------------------------------------------------------------
module pcx_rle_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRequests = 220;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleDelay = 8;
  localparam logic [7:0]  LitMax      = 8'hBF;

  typedef struct packed {
    pcx_pkg::kind_e             kind;
    logic [7:0]                 pixel;
    logic                       last;
    logic [pcx_pkg::ColorW-1:0] colors;
  } decoded_t;

  // Tracks one image being expanded and queues the results it will give
  class pcx_expander_model;
    logic [pcx_pkg::ImgW-1:0]   image_bytes;
    bit                         run_held;
    logic [pcx_pkg::CntW-1:0]   run_count;
    logic [pcx_pkg::ImgW-1:0]   written;
    pcx_pkg::phase_e            stage;
    bit                         color_seen [pcx_pkg::NColor];
    logic [pcx_pkg::ColorW-1:0] color_count;
    decoded_t                   pending_results [$];
    int                         mismatches;

    function new();
      image_bytes = pcx_pkg::ImgW'(1);
      mismatches  = 0;
      clear_image();
    endfunction

    function void clear_image();
      run_held    = 1'b0;
      run_count   = '0;
      written     = '0;
      stage       = pcx_pkg::PHASE_ACTIVE;
      foreach (color_seen[i]) color_seen[i] = 1'b0;
      color_count = '0;
    endfunction

    function void mark_color(logic [7:0] v);
      if (!color_seen[v]) begin
        color_seen[v] = 1'b1;
        color_count   = color_count + 1'b1;
      end
    endfunction

    function void add(pcx_pkg::kind_e kind, logic [7:0] pix);
      decoded_t r;
      r.kind   = kind;
      r.pixel  = pix;
      r.last   = 1'b0;
      r.colors = color_count;
      pending_results.push_back(r);
    endfunction

    // Flag the final result of a request, if it gave any
    function void close_burst(int unsigned base);
      decoded_t r;
      if (pending_results.size() > base) begin
        r      = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    endfunction

    // Returns 0 when the request is a data byte that the block ignores
    function bit absorb_request(logic op, logic [7:0] b, logic eob);
      int unsigned              base;
      logic [pcx_pkg::ImgW-1:0] room;
      logic [pcx_pkg::ImgW-1:0] span;
      bit                       fits;
      base = pending_results.size();
      if (!op) begin
        clear_image();
        return 1'b1;
      end
      if (stage != pcx_pkg::PHASE_ACTIVE) return 1'b0;
      if (written >= image_bytes) begin
        stage = pcx_pkg::PHASE_COMPLETE;
        add(pcx_pkg::KIND_DONE, 8'h00);
        close_burst(base);
        return 1'b1;
      end
      if (run_held) begin
        room = image_bytes - written;
        fits = ({{(pcx_pkg::ImgW-pcx_pkg::CntW){1'b0}}, run_count} <= room);
        span = fits ? {{(pcx_pkg::ImgW-pcx_pkg::CntW){1'b0}}, run_count} : room;
        run_held  = 1'b0;
        run_count = '0;
        if (fits) mark_color(b);
        for (int unsigned i = 0; i < span; i++) add(pcx_pkg::KIND_PIXEL, b);
        written = written + span;
        if (!fits) begin
          stage = pcx_pkg::PHASE_ERROR;
          add(pcx_pkg::KIND_OVERRUN, 8'h00);
          close_burst(base);
          return 1'b1;
        end
      end else if ((b & pcx_pkg::RunMark) == pcx_pkg::RunMark) begin
        run_held  = 1'b1;
        run_count = b[pcx_pkg::CntW-1:0] & pcx_pkg::RunMask;
      end else begin
        mark_color(b);
        add(pcx_pkg::KIND_PIXEL, b);
        written = written + 1'b1;
      end
      // Image full wins over an early end of buffer
      if (written >= image_bytes) begin
        stage     = pcx_pkg::PHASE_COMPLETE;
        run_held  = 1'b0;
        run_count = '0;
        add(pcx_pkg::KIND_DONE, 8'h00);
      end else if (eob) begin
        stage     = pcx_pkg::PHASE_ERROR;
        run_held  = 1'b0;
        run_count = '0;
        add(pcx_pkg::KIND_SHORT, 8'h00);
      end
      close_burst(base);
      return 1'b1;
    endfunction

    function void compare_result(logic [1:0] kind, logic [7:0] pix, logic last,
                                 logic [pcx_pkg::ColorW-1:0] colors);
      decoded_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d pixel_byte 0x%02h", kind, pix);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (pix !== want.pixel) begin
        $error("pixel_byte: expected 0x%02h, got 0x%02h", want.pixel, pix);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
      if (colors !== want.colors) begin
        $error("colors_used: expected %0d, got %0d", want.colors, colors);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_we_i        = 1'b0;
  logic [pcx_pkg::ImgW-1:0]   cfg_wdata_i     = '0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic                       op_i            = 1'b0;
  logic [7:0]                 data_byte_i     = 8'h00;
  logic                       end_of_buffer_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [1:0]                 kind_o;
  logic [7:0]                 pixel_byte_o;
  logic                       last_o;
  logic [pcx_pkg::ColorW-1:0] colors_used_o;

  pcx_expander_model expander;
  int unsigned       n_taken       = 0;
  bit                burst_mode    = 1'b0;
  bit                long_hold_req = 1'b0;
  longint            cur_size      = 1;

  pcx_rle_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .pixel_byte_o    (pixel_byte_o),
    .last_o          (last_o),
    .colors_used_o   (colors_used_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check results and note accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        expander.compare_result(kind_o, pixel_byte_o, last_o, colors_used_o);
      end
      if (in_valid_i && !in_stall_o) begin
        if (expander.absorb_request(op_i, data_byte_i, end_of_buffer_i)) n_taken++;
      end
    end
  end

  // Abort when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: stall in random stretches, once for a long hold-off
  initial begin : receiver
    int unsigned span;
    int unsigned style;
    bit          held;
    held = 1'b0;
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      span  = $urandom_range(1, 40);
      style = $urandom_range(0, 9);
      repeat (span) begin
        case (style) inside
          [0:2]: begin
            out_stall_i <= 1'b0;
          end
          [3:6]: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          [7:8]: begin
            out_stall_i <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall_i <= 1'b1;
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_req(logic op, logic [7:0] b, logic eob);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    data_byte_i     <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain every expected result, then let a silent request finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expander.pending_results.size() != 0);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic write_image_bytes(logic [pcx_pkg::ImgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    expander.image_bytes = v;
    cur_size = v;
  endtask

  function automatic logic [pcx_pkg::ImgW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return pcx_pkg::ImgW'($urandom_range(1, 40));
    if (r < 85) return pcx_pkg::ImgW'($urandom_range(41, 400));
    if (r < 90) return pcx_pkg::ImgW'(32'd16777216);
    if (r < 94) return pcx_pkg::ImgW'(32'd16777215);
    return pcx_pkg::ImgW'($urandom_range(1, 16777216));
  endfunction

  // Well-formed stream: literals and runs that never pass the image end
  task automatic stream_image();
    longint      left;
    int unsigned cap;
    int unsigned sent;
    int unsigned cnt;
    bit          fin;
    logic [7:0]  b;
    left = cur_size;
    cap  = $urandom_range(4, 40);
    sent = 0;
    while (left > 0 && sent < cap) begin
      if ($urandom_range(0, 99) < 45) begin
        b    = 8'($urandom_range(0, LitMax));
        left = left - 1;
        fin  = (left == 0) || (sent + 1 >= cap);
        send_req(1'b1, b, fin ? 1'($urandom_range(0, 1)) : 1'b0);
      end else begin
        cnt  = $urandom_range(0, (left < 63) ? 32'(left) : 32'd63);
        left = left - cnt;
        fin  = (left == 0) || (sent + 1 >= cap);
        send_req(1'b1, pcx_pkg::RunMark | 8'(cnt), 1'b0);
        send_req(1'b1, 8'($urandom_range(0, 255)), fin ? 1'($urandom_range(0, 1)) : 1'b0);
      end
      sent++;
    end
    // Trailing bytes after the image ends are dropped by the block
    if ($urandom_range(0, 9) == 0) send_req(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // Noise: any bytes, stray new-image requests, early end of buffer
  task automatic stream_noise();
    int unsigned n;
    n = $urandom_range(2, 14);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        send_req(1'b0, 8'($urandom), 1'($urandom));
      end else if ($urandom_range(0, 99) < 40) begin
        send_req(1'b1, pcx_pkg::RunMark | 8'($urandom_range(0, 63)),
                 ($urandom_range(0, 11) == 0));
      end else begin
        send_req(1'b1, 8'($urandom), ($urandom_range(0, 11) == 0));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned img_count;
    expander = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Image of one byte at the reset size, then a byte after completion
    send_req(1'b1, 8'h05, 1'b0);
    send_req(1'b1, 8'hFF, 1'b1);

    // Literal, run, zero-length run, final literal fills the image
    wait_idle();
    write_image_bytes(pcx_pkg::ImgW'(5));
    send_req(1'b0, 8'hA5, 1'b1);
    send_req(1'b1, 8'h00, 1'b0);
    send_req(1'b1, 8'hC3, 1'b0);
    send_req(1'b1, 8'hFF, 1'b0);
    send_req(1'b1, 8'hC0, 1'b0);
    send_req(1'b1, 8'h7A, 1'b0);
    send_req(1'b1, LitMax, 1'b0);

    // Run that passes the image end, then an ignored byte
    send_req(1'b0, 8'h00, 1'b0);
    send_req(1'b1, 8'h01, 1'b0);
    send_req(1'b1, 8'hCA, 1'b0);
    send_req(1'b1, 8'h22, 1'b0);
    send_req(1'b1, 8'h33, 1'b0);

    // Buffer ends early, on a literal and on a count byte
    send_req(1'b0, 8'h00, 1'b0);
    send_req(1'b1, 8'h80, 1'b1);
    send_req(1'b0, 8'h00, 1'b0);
    send_req(1'b1, 8'hC2, 1'b1);

    // Image size lowered below the bytes already written
    send_req(1'b0, 8'h00, 1'b0);
    send_req(1'b1, 8'h10, 1'b0);
    send_req(1'b1, 8'h20, 1'b0);
    send_req(1'b1, 8'h30, 1'b0);
    wait_idle();
    write_image_bytes(pcx_pkg::ImgW'(2));
    send_req(1'b1, 8'h40, 1'b0);

    // Largest size: longest run, then end of buffer
    wait_idle();
    write_image_bytes(pcx_pkg::ImgW'(32'd16777216));
    send_req(1'b0, 8'h00, 1'b0);
    send_req(1'b1, 8'hFF, 1'b0);
    send_req(1'b1, 8'hC7, 1'b1);
    wait_idle();
    write_image_bytes(pcx_pkg::ImgW'(32'd16777215));
    send_req(1'b0, 8'h00, 1'b0);
    send_req(1'b1, 8'h55, 1'b1);

    // Random images, mostly well formed
    img_count = 0;
    while (n_taken < NumRequests) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if (img_count == 1) begin
        wait_idle();
        write_image_bytes(pcx_pkg::ImgW'(200));
        burst_mode = 1'b1;
        long_hold_req <= 1'b1;
      end else if ($urandom_range(0, 99) < 40) begin
        wait_idle();
        write_image_bytes(pick_size());
      end
      if ($urandom_range(0, 9) != 0 || img_count == 1) begin
        send_req(1'b0, 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 99) < 75 || img_count == 1) begin
        stream_image();
      end else begin
        stream_noise();
      end
      img_count++;
    end

    // Drain and let the block settle
    burst_mode = 1'b0;
    wait_idle();
    if (expander.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", expander.pending_results.size());
      expander.mismatches++;
    end
    if (expander.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
